[hw/rtl/tbts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band tone stack filter: shared package
// Types, constants and the microcode program used by the sequencer, the
// datapath and the top level.
// ----------------------------------------------------------------------------
package tbts_pkg;

   // Default widths of the sample path and the capacitor state.
   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int STATE_WIDTH_DEF  = 32;

   // Coefficient formats.
   localparam int COEF_W    = 24;
   localparam int COEF_FRAC = 20;
   localparam int MIX_W     = 17;
   localparam int MIX_FRAC  = 16;
   localparam logic [MIX_W-1:0] MIX_FULL = 17'd65536;
   localparam logic [MIX_W-1:0] MIX_RESET = 17'd32768;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_KA1 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KA2 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KM1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KM2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KB  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX = 3'd5;

   // Program counter width of the microcode sequencer.
   localparam int STEP_W = 5;

   // Coefficient register set.
   typedef struct packed {
      logic signed [COEF_W-1:0] ka1;
      logic signed [COEF_W-1:0] ka2;
      logic signed [COEF_W-1:0] km1;
      logic signed [COEF_W-1:0] km2;
      logic signed [COEF_W-1:0] kb;
      logic        [MIX_W-1:0]  mix;
   } coef_set_type;

   // Multiplier operand register.
   typedef enum logic [1:0] {
      MSRC_D1,
      MSRC_D2,
      MSRC_E,
      MSRC_F
   } mul_src_type;

   // Multiplier coefficient.
   typedef enum logic [2:0] {
      COEF_KA1,
      COEF_KA2,
      COEF_KM1,
      COEF_KM2,
      COEF_KB,
      COEF_MIX
   } coef_sel_type;

   // Accumulator operation on the registered product.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // Subtractor operation.
   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_D1,
      ALU_D2,
      ALU_V1,
      ALU_E1,
      ALU_E2,
      ALU_F
   } alu_op_type;

   // Write-back of the rounded accumulator.
   typedef enum logic [2:0] {
      WB_NOP,
      WB_A,
      WB_M,
      WB_V2,
      WB_Y
   } wb_op_type;

   // Step hold condition.
   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_OUT
   } wait_type;

   // One control word of the program.
   typedef struct packed {
      logic              mul_en;
      logic              mul_hi;
      mul_src_type       mul_src;
      coef_sel_type      coef_sel;
      acc_op_type        acc_op;
      alu_op_type        alu_op;
      wb_op_type         wb_op;
      wait_type          wait_cond;
      logic              jump;
      logic [STEP_W-1:0] jump_target;
   } ctrl_word_type;

   localparam ctrl_word_type UCODE_NOP = '{
      mul_en:      1'b0,
      mul_hi:      1'b0,
      mul_src:     MSRC_D1,
      coef_sel:    COEF_KA1,
      acc_op:      ACC_HOLD,
      alu_op:      ALU_NOP,
      wb_op:       WB_NOP,
      wait_cond:   WAIT_NONE,
      jump:        1'b0,
      jump_target: '0
   };

   // Adds a partial product to a control word.
   function automatic ctrl_word_type with_mul(input ctrl_word_type w_in, input logic hi,
                                              input mul_src_type src,
                                              input coef_sel_type coef);
      ctrl_word_type w;
      w          = w_in;
      w.mul_en   = 1'b1;
      w.mul_hi   = hi;
      w.mul_src  = src;
      w.coef_sel = coef;
      return w;
   endfunction

   // The program: one sample per pass. Products are registered after the multiplier
   // and reach the accumulator in the next step.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = UCODE_NOP;
      unique case (step)
         5'd0: begin
            w.wait_cond = WAIT_REQ;
         end
         5'd1: begin
            w.alu_op = ALU_D1;
         end
         5'd2: begin
            w.alu_op = ALU_D2;
         end
         5'd3: begin
            w = with_mul(w, 1'b0, MSRC_D1, COEF_KA1);
         end
         5'd4: begin
            w = with_mul(w, 1'b1, MSRC_D1, COEF_KA1);
            w.acc_op = ACC_LOAD;
         end
         5'd5: begin
            w = with_mul(w, 1'b0, MSRC_D2, COEF_KA2);
            w.acc_op = ACC_ADD;
         end
         5'd6: begin
            w = with_mul(w, 1'b1, MSRC_D2, COEF_KA2);
            w.acc_op = ACC_ADD;
         end
         5'd7: begin
            w = with_mul(w, 1'b0, MSRC_D1, COEF_KM1);
            w.acc_op = ACC_ADD;
         end
         5'd8: begin
            w = with_mul(w, 1'b1, MSRC_D1, COEF_KM1);
            w.acc_op = ACC_LOAD;
            w.wb_op  = WB_A;
         end
         5'd9: begin
            w = with_mul(w, 1'b0, MSRC_D2, COEF_KM2);
            w.acc_op = ACC_ADD;
         end
         5'd10: begin
            w = with_mul(w, 1'b1, MSRC_D2, COEF_KM2);
            w.acc_op = ACC_ADD;
            w.alu_op = ALU_V1;
         end
         5'd11: begin
            w.acc_op = ACC_ADD;
         end
         5'd12: begin
            w.wb_op = WB_M;
         end
         5'd13: begin
            w.alu_op = ALU_E1;
         end
         5'd14: begin
            w.alu_op = ALU_E2;
         end
         5'd15: begin
            w = with_mul(w, 1'b0, MSRC_E, COEF_KB);
            w.alu_op = ALU_F;
         end
         5'd16: begin
            w = with_mul(w, 1'b1, MSRC_E, COEF_KB);
            w.acc_op = ACC_LOAD;
         end
         5'd17: begin
            w = with_mul(w, 1'b0, MSRC_F, COEF_MIX);
            w.acc_op = ACC_ADD;
         end
         5'd18: begin
            w = with_mul(w, 1'b1, MSRC_F, COEF_MIX);
            w.acc_op = ACC_LOAD;
            w.wb_op  = WB_V2;
         end
         5'd19: begin
            w.acc_op = ACC_ADD;
         end
         5'd20: begin
            w.wb_op       = WB_Y;
            w.wait_cond   = WAIT_OUT;
            w.jump        = 1'b1;
            w.jump_target = '0;
         end
         default: begin
            // Unused steps return to the idle step.
            w.jump        = 1'b1;
            w.jump_target = '0;
         end
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/tbts_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone stack microcode sequencer
// Step counter over the program table, with hold conditions on the input
// and output channels and jumps back to the idle step.
// ----------------------------------------------------------------------------
module tbts_seq
   import tbts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   output ctrl_word_type ctrl
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   logic              hold;

   // Control word of the current step.
   assign ctrl = ucode_rom(pc_ff);

   // A step holds while its channel is not ready, then jumps or moves on.
   always_comb begin
      hold = ((ctrl.wait_cond == WAIT_REQ) && !req_valid) ||
             ((ctrl.wait_cond == WAIT_OUT) && !out_free);
      priority if (hold) begin
         pc_in = pc_ff;
      end else if (ctrl.jump) begin
         pc_in = ctrl.jump_target;
      end else begin
         pc_in = pc_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[hw/rtl/tbts_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone stack datapath
// Operand registers, one subtractor, one shared split multiplier with a
// product register, an accumulator, and rounding with saturation.
// ----------------------------------------------------------------------------
module tbts_dp
   import tbts_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_word_type                  ctrl,
   input  logic                           accept,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  coef_set_type                   coefs,
   output logic signed [SAMPLE_WIDTH-1:0] y_value
);

   localparam int MW   = (STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH;
   localparam int OW   = MW + 2;             // operand width, holds x - m - v2
   localparam int LO_W = (OW + 1) / 2;       // low part of a split operand
   localparam int MA   = LO_W + 1;           // signed multiplier operand width
   localparam int PW   = MA + COEF_W;        // product width
   localparam int ACCW = OW + COEF_W + 1;    // exact sum of two full products
   localparam int SUMW = ACCW + 1;           // write-back sum width

   localparam logic signed [ACCW-1:0] HALF_Q20 = ACCW'(2 ** (COEF_FRAC - 1));
   localparam logic signed [ACCW-1:0] HALF_Q16 = ACCW'(2 ** (MIX_FRAC - 1));

   localparam logic signed [SUMW-1:0] ST_MAX =
      {{(SUMW - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
   localparam logic signed [SUMW-1:0] ST_MIN =
      {{(SUMW - STATE_WIDTH + 1){1'b1}}, {(STATE_WIDTH - 1){1'b0}}};
   localparam logic signed [SUMW-1:0] SW_MAX =
      {{(SUMW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SUMW-1:0] SW_MIN =
      {{(SUMW - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [SUMW-1:0] v);
      logic signed [STATE_WIDTH-1:0] r;
      if (v > ST_MAX) begin
         r = ST_MAX[STATE_WIDTH-1:0];
      end else if (v < ST_MIN) begin
         r = ST_MIN[STATE_WIDTH-1:0];
      end else begin
         r = v[STATE_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [SUMW-1:0] v);
      logic signed [SAMPLE_WIDTH-1:0] r;
      if (v > SW_MAX) begin
         r = SW_MAX[SAMPLE_WIDTH-1:0];
      end else if (v < SW_MIN) begin
         r = SW_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         r = v[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [STATE_WIDTH-1:0]  v1_ff, v1_in, v2_ff, v2_in;
   logic signed [STATE_WIDTH-1:0]  a_ff, a_in, m_ff, m_in;
   logic signed [OW-1:0]           d1_ff, d1_in, d2_ff, d2_in;
   logic signed [OW-1:0]           e_ff, e_in, f_ff, f_in;
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic                           prod_hi_ff, prod_hi_in;
   logic signed [ACCW-1:0]         acc_ff, acc_in;

   logic signed [OW-1:0]     alu_a, alu_b, alu_diff;
   logic signed [OW-1:0]     mul_op;
   logic signed [MA-1:0]     mul_part;
   logic signed [COEF_W-1:0] mul_coef;
   logic        [MIX_W-1:0]  mix_clamp;
   logic signed [ACCW-1:0]   prod_ext, acc_term;
   logic signed [ACCW-1:0]   rnd;
   logic signed [SUMW-1:0]   wb_base, wb_sum;

   // Subtractor: differences of sample, state and intermediates.
   always_comb begin
      unique case (ctrl.alu_op)
         ALU_D1: begin
            alu_a = OW'(x_ff);
            alu_b = OW'(v1_ff);
         end
         ALU_D2: begin
            alu_a = OW'(x_ff);
            alu_b = OW'(v2_ff);
         end
         ALU_V1: begin
            alu_a = OW'(x_ff);
            alu_b = OW'(a_ff);
         end
         ALU_E1: begin
            alu_a = OW'(x_ff);
            alu_b = OW'(m_ff);
         end
         ALU_E2: begin
            alu_a = e_ff;
            alu_b = OW'(v2_ff);
         end
         ALU_F: begin
            alu_a = OW'(a_ff);
            alu_b = OW'(m_ff);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
      alu_diff = alu_a - alu_b;
   end

   // Multiplier operands: one half of an operand register times a coefficient.
   always_comb begin
      unique case (ctrl.mul_src)
         MSRC_D1: mul_op = d1_ff;
         MSRC_D2: mul_op = d2_ff;
         MSRC_E:  mul_op = e_ff;
         MSRC_F:  mul_op = f_ff;
         default: mul_op = d1_ff;
      endcase
      if (ctrl.mul_hi) begin
         mul_part = MA'($signed(mul_op[OW-1:LO_W]));
      end else begin
         mul_part = $signed({1'b0, mul_op[LO_W-1:0]});
      end
      mix_clamp = (coefs.mix > MIX_FULL) ? MIX_FULL : coefs.mix;
      unique case (ctrl.coef_sel)
         COEF_KA1: mul_coef = coefs.ka1;
         COEF_KA2: mul_coef = coefs.ka2;
         COEF_KM1: mul_coef = coefs.km1;
         COEF_KM2: mul_coef = coefs.km2;
         COEF_KB:  mul_coef = coefs.kb;
         COEF_MIX: mul_coef = $signed(COEF_W'(mix_clamp));
         default:  mul_coef = '0;
      endcase
      prod_in    = ctrl.mul_en ? (mul_part * mul_coef) : prod_ff;
      prod_hi_in = ctrl.mul_en ? ctrl.mul_hi : prod_hi_ff;
   end

   // Accumulator takes the registered product, shifted up for a high half.
   always_comb begin
      prod_ext = ACCW'(prod_ff);
      acc_term = prod_hi_ff ? (prod_ext <<< LO_W) : prod_ext;
      unique case (ctrl.acc_op)
         ACC_LOAD: acc_in = acc_term;
         ACC_ADD:  acc_in = acc_ff + acc_term;
         default:  acc_in = acc_ff;
      endcase
   end

   // Round half up, add the base term and saturate.
   always_comb begin
      if (ctrl.wb_op == WB_Y) begin
         rnd = (acc_ff + HALF_Q16) >>> MIX_FRAC;
      end else begin
         rnd = (acc_ff + HALF_Q20) >>> COEF_FRAC;
      end
      unique case (ctrl.wb_op)
         WB_V2:   wb_base = SUMW'(v2_ff);
         WB_Y:    wb_base = SUMW'(m_ff);
         default: wb_base = '0;
      endcase
      wb_sum  = wb_base + SUMW'(rnd);
      y_value = sat_sample(wb_sum);
   end

   // Next values of the working registers.
   always_comb begin
      x_in  = accept ? sample_in : x_ff;
      d1_in = (ctrl.alu_op == ALU_D1) ? alu_diff : d1_ff;
      d2_in = (ctrl.alu_op == ALU_D2) ? alu_diff : d2_ff;
      e_in  = ((ctrl.alu_op == ALU_E1) || (ctrl.alu_op == ALU_E2)) ? alu_diff : e_ff;
      f_in  = (ctrl.alu_op == ALU_F) ? alu_diff : f_ff;
      a_in  = (ctrl.wb_op == WB_A) ? sat_state(wb_sum) : a_ff;
      m_in  = (ctrl.wb_op == WB_M) ? sat_state(wb_sum) : m_ff;
      v1_in = (ctrl.alu_op == ALU_V1) ? sat_state(SUMW'(alu_diff)) : v1_ff;
      v2_in = (ctrl.wb_op == WB_V2) ? sat_state(wb_sum) : v2_ff;
   end

   // Capacitor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
         v2_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      e_ff       <= e_in;
      f_ff       <= f_in;
      a_ff       <= a_in;
      m_ff       <= m_in;
      prod_ff    <= prod_in;
      prod_hi_ff <= prod_hi_in;
      acc_ff     <= acc_in;
   end

endmodule

[hw/rtl/three_band_tone_stack_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band tone stack filter
// Per sample, a passive treble/bass/mid tone network with two capacitor
// states, driven by a microcoded sequencer over one shared multiplier.
//
// Usage:
//   req_* carries one input sample per beat, rsp_* one filtered sample per
//   beat, csr_* writes the coefficient registers (index 0 to 5; higher
//   indexes are ignored). csr_ready is high whenever reset is low; write
//   coefficients only while no sample is in flight.
//   A sample is accepted in the idle step of the program. Its result is
//   registered in the last step, and the next sample is accepted once the
//   program is back in the idle step. The length of a pass is set by the twelve
//   partial products that share the single multiplier, plus the chain of
//   subtractions between them.
//   A result waits in the output register while rsp_tready is low; the block
//   works on the next sample meanwhile and holds in its last step only if
//   that result is done before the register drains.
//   Reset clears both capacitor states, zeroes the coefficients, sets the
//   treble mix to half and drops rsp_tvalid, req_tready and csr_ready.
// ----------------------------------------------------------------------------
module three_band_tone_stack_filter_top
   import tbts_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = STATE_WIDTH_DEF,
   localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input samples.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W-1:0]     req_tdata,   // sample_in, zero padded
   // Filtered samples.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_W-1:0]     rsp_tdata,   // sample_out, zero padded
   // Coefficient writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata
);

   ctrl_word_type                  ctrl;
   coef_set_type                   coef_ff, coef_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [TDATA_W-1:0]             rsp_tdata_ff, rsp_tdata_in;
   logic                           accept;
   logic                           out_free;
   logic                           y_load;
   logic signed [SAMPLE_WIDTH-1:0] y_value;

   // Handshakes.
   assign req_tready = (ctrl.wait_cond == WAIT_REQ) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign y_load     = (ctrl.wb_op == WB_Y) && out_free;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   tbts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   tbts_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STATE_WIDTH  (STATE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .accept    (accept),
      .sample_in ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .coefs     (coef_ff),
      .y_value   (y_value)
   );

   // Coefficient register writes.
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_KA1: coef_in.ka1 = $signed(csr_wdata);
            REG_KA2: coef_in.ka2 = $signed(csr_wdata);
            REG_KM1: coef_in.km1 = $signed(csr_wdata);
            REG_KM2: coef_in.km2 = $signed(csr_wdata);
            REG_KB:  coef_in.kb  = $signed(csr_wdata);
            REG_MIX: coef_in.mix = csr_wdata[MIX_W-1:0];
            default: coef_in = coef_ff;
         endcase
      end
   end

   // Output register: loaded when the last step finds it free.
   always_comb begin
      rsp_tdata_in = y_load ? TDATA_W'($unsigned(y_value)) : rsp_tdata_ff;
      priority if (y_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff       <= '{ka1: '0, ka2: '0, km1: '0, km2: '0, kb: '0, mix: MIX_RESET};
         rsp_tvalid_ff <= 1'b0;
      end else begin
         coef_ff       <= coef_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule
